/* hw/rtl/radar_plot_window_gate_defines.svh */
// Assertion macros for the plot window gate.
`ifndef RADAR_PLOT_WINDOW_GATE_DEFINES_SVH
`define RADAR_PLOT_WINDOW_GATE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RPWG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RPWG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/rpwg_pkg.sv */
// Package: constants, register indexes and types of the plot window gate.
`default_nettype none

package rpwg_pkg;

    localparam int RangeW = 20;
    localparam int AngW   = 16;
    localparam int PayW   = 64;
    localparam int GeomW  = RangeW + 2 * AngW;
    localparam int SlotW  = 6;
    localparam int PcntW  = 7;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 20;

    localparam logic [RangeW-1:0]      RangeDefLow   = 20'd1600;
    localparam logic [RangeW-1:0]      RangeDefHigh  = 20'd800000;
    localparam logic signed [AngW-1:0] ElevLimit     = 16'sd12861;
    localparam logic signed [AngW-1:0] ElevDefLow    = -16'sd1430;
    localparam logic signed [AngW-1:0] ElevDefHigh   = 16'sd8577;
    localparam logic signed [AngW-1:0] AzimLimit     = 16'sd25735;
    localparam logic signed [AngW-1:0] AzimDefLow    = -16'sd8577;
    localparam logic signed [AngW-1:0] AzimDefHigh   = 16'sd8577;
    localparam logic [PcntW-1:0]       PcntDef       = 7'd32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_RANGE_MIN   = 3'd0,
        REG_RANGE_MAX   = 3'd1,
        REG_ELEV_MIN    = 3'd2,
        REG_ELEV_MAX    = 3'd3,
        REG_AZIM_MIN    = 3'd4,
        REG_AZIM_MAX    = 3'd5,
        REG_POINT_COUNT = 3'd6,
        REG_UNUSED      = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_GATE = 3'b010,
        S_EMIT = 3'b100
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/radar_plot_window_gate.sv */
// Top level: detection window gate, per-frame compaction store and slot emitter.
//
//  channel   | handshake           | fields
//  ----------+---------------------+-----------------------------------------------
//  input     | start / busy        | i_frame_sel i_range_q i_elev_q i_azim_q
//            |                     | i_flag_in i_payload i_last_in
//  result    | o_strobe            | o_out_slot o_out_valid o_out_range o_out_elev
//            |                     | o_out_azim o_out_payload o_out_last
//  config    | i_cfg_we            | i_cfg_idx i_cfg_data
//
// A detection is captured, then gated and written to the store; busy holds off the next one meanwhile.
// An item with i_last_in then emits min(point_count, MAX_POINTS) slots, one
// store read per slot; each result is registered from its read and shows in the cycle after.
// Reset (synchronous) restores register defaults and clears both kept counts;
// the stores are not cleared, padding slots read stale entries and drive zero.
// Results cannot be stalled; each transfer is one o_strobe cycle.
`default_nettype none

`include "radar_plot_window_gate_defines.svh"

module radar_plot_window_gate
    import rpwg_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire                        i_cfg_we,
    input  wire  [CfgIdxW-1:0]         i_cfg_idx,
    input  wire  [CfgDataW-1:0]        i_cfg_data,
    input  wire                        i_frame_sel,
    input  wire  [RangeW-1:0]          i_range_q,
    input  wire  signed [AngW-1:0]     i_elev_q,
    input  wire  signed [AngW-1:0]     i_azim_q,
    input  wire                        i_flag_in,
    input  wire  [PayW-1:0]            i_payload,
    input  wire                        i_last_in,
    output logic                       o_strobe,
    output logic [SlotW-1:0]           o_out_slot,
    output logic                       o_out_valid,
    output logic [RangeW-1:0]          o_out_range,
    output logic signed [AngW-1:0]     o_out_elev,
    output logic signed [AngW-1:0]     o_out_azim,
    output logic [PayW-1:0]            o_out_payload,
    output logic                       o_out_last
);

    localparam int Depth = 2 * MAX_POINTS;
    localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CW    = $clog2(MAX_POINTS + 1);

    // configuration
    logic [RangeW-1:0]      r_range_min, r_range_max;
    logic signed [AngW-1:0] r_elev_min, r_elev_max, r_azim_min, r_azim_max;
    logic [PcntW-1:0]       r_point_count;

    // effective windows
    logic [RangeW-1:0]      win_rhi;
    logic signed [AngW-1:0] win_elo, win_ehi, win_alo, win_ahi;

    // captured item
    logic                   r_in_sel, r_in_flag, r_in_last;
    logic [RangeW-1:0]      r_in_range;
    logic signed [AngW-1:0] r_in_elev, r_in_azim;
    logic [PayW-1:0]        r_in_pay;

    t_state                 r_state, n_state;
    logic [CW-1:0]          r_prev_cnt, n_prev_cnt, r_cur_cnt, n_cur_cnt;
    logic [CW-1:0]          r_emit_n, n_emit_n, r_k, n_k;
    logic                   r_use_cur, n_use_cur;

    logic [CW-1:0]          lim, cnt_sel, prev_after, cur_after;
    logic                   keep, wr_en, rd_en;
    logic [AW-1:0]          wr_addr, rd_addr;

    // stores
    logic [GeomW-1:0]       geom_mem [Depth];
    logic [PayW-1:0]        pay_mem  [Depth];
    logic [GeomW-1:0]       r_rd_geom;
    logic [PayW-1:0]        r_rd_pay;

    // output stage
    logic                   r_strobe, r_out_valid, r_out_last;
    logic [SlotW-1:0]       r_out_slot;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min   <= RangeDefLow;
            r_range_max   <= RangeDefHigh;
            r_elev_min    <= ElevDefLow;
            r_elev_max    <= ElevDefHigh;
            r_azim_min    <= AzimDefLow;
            r_azim_max    <= AzimDefHigh;
            r_point_count <= PcntDef;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_RANGE_MIN:   r_range_min   <= i_cfg_data[RangeW-1:0];
                REG_RANGE_MAX:   r_range_max   <= i_cfg_data[RangeW-1:0];
                REG_ELEV_MIN:    r_elev_min    <= i_cfg_data[AngW-1:0];
                REG_ELEV_MAX:    r_elev_max    <= i_cfg_data[AngW-1:0];
                REG_AZIM_MIN:    r_azim_min    <= i_cfg_data[AngW-1:0];
                REG_AZIM_MAX:    r_azim_max    <= i_cfg_data[AngW-1:0];
                REG_POINT_COUNT: r_point_count <= i_cfg_data[PcntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        win_rhi = (r_range_max > r_range_min) ? r_range_max : RangeDefHigh;
        win_elo = (r_elev_min >= -ElevLimit && r_elev_min < r_elev_max) ? r_elev_min
                                                                        : ElevDefLow;
        win_ehi = (r_elev_max > win_elo && r_elev_max <= ElevLimit) ? r_elev_max
                                                                    : ElevDefHigh;
        win_alo = (r_azim_min >= -AzimLimit && r_azim_min < r_azim_max) ? r_azim_min
                                                                        : AzimDefLow;
        win_ahi = (r_azim_max > win_alo && r_azim_max <= AzimLimit) ? r_azim_max
                                                                    : AzimDefHigh;
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in_sel   <= i_frame_sel;
            r_in_range <= i_range_q;
            r_in_elev  <= i_elev_q;
            r_in_azim  <= i_azim_q;
            r_in_flag  <= i_flag_in;
            r_in_pay   <= i_payload;
            r_in_last  <= i_last_in;
        end
    end

    always_comb begin
        lim = (r_point_count > PcntW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_point_count);
        cnt_sel = r_in_sel ? r_cur_cnt : r_prev_cnt;
        keep = r_in_flag && r_in_range >= r_range_min && r_in_range <= win_rhi
            && r_in_elev >= win_elo && r_in_elev <= win_ehi
            && r_in_azim >= win_alo && r_in_azim <= win_ahi;
        wr_en = (r_state == S_GATE) && keep && (cnt_sel < lim);
        wr_addr = r_in_sel ? AW'(MAX_POINTS) + AW'(cnt_sel) : AW'(cnt_sel);
        prev_after = (wr_en && !r_in_sel) ? r_prev_cnt + 1'b1 : r_prev_cnt;
        cur_after  = (wr_en && r_in_sel)  ? r_cur_cnt + 1'b1  : r_cur_cnt;
        rd_en = (r_state == S_EMIT);
        rd_addr = r_use_cur ? AW'(MAX_POINTS) + AW'(r_k) : AW'(r_k);

        n_state    = r_state;
        n_prev_cnt = r_prev_cnt;
        n_cur_cnt  = r_cur_cnt;
        n_emit_n   = r_emit_n;
        n_use_cur  = r_use_cur;
        n_k        = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_GATE;
                end
            end
            S_GATE: begin
                n_prev_cnt = prev_after;
                n_cur_cnt  = cur_after;
                n_state    = S_IDLE;
                if (r_in_last) begin
                    n_use_cur  = (cur_after != '0);
                    n_emit_n   = (cur_after != '0) ? cur_after : prev_after;
                    n_prev_cnt = '0;
                    n_cur_cnt  = '0;
                    n_k        = '0;
                    if (lim != '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                n_k = r_k + 1'b1;
                if (r_k == lim - 1'b1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_prev_cnt <= '0;
            r_cur_cnt  <= '0;
            r_emit_n   <= '0;
            r_use_cur  <= 1'b0;
            r_k        <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_prev_cnt <= n_prev_cnt;
            r_cur_cnt  <= n_cur_cnt;
            r_emit_n   <= n_emit_n;
            r_use_cur  <= n_use_cur;
            r_k        <= n_k;
            r_strobe   <= rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            geom_mem[wr_addr] <= {r_in_azim, r_in_elev, r_in_range};
            pay_mem[wr_addr]  <= r_in_pay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_geom   <= geom_mem[rd_addr];
            r_rd_pay    <= pay_mem[rd_addr];
            r_out_slot  <= SlotW'(r_k);
            r_out_valid <= (r_k < r_emit_n);
            r_out_last  <= (r_k == lim - 1'b1);
        end
    end

    assign o_strobe      = r_strobe;
    assign o_out_slot    = r_out_slot;
    assign o_out_valid   = r_out_valid;
    assign o_out_last    = r_out_last;
    assign o_out_range   = r_out_valid ? r_rd_geom[RangeW-1:0] : '0;
    assign o_out_elev    = r_out_valid ? r_rd_geom[RangeW+AngW-1:RangeW] : '0;
    assign o_out_azim    = r_out_valid ? r_rd_geom[GeomW-1:RangeW+AngW] : '0;
    assign o_out_payload = r_out_valid ? r_rd_pay : '0;

    `RPWG_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == S_EMIT, r_strobe, "emit read without result transfer")
    `RPWG_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, r_state == S_GATE, "accepted item not gated")
    `RPWG_ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, r_strobe && r_out_last, !r_strobe, "transfer after final slot")
    `RPWG_ASSERT_NOW(a_cnt_cap, i_clk, i_rst_n, r_state == S_GATE, r_prev_cnt <= lim && r_cur_cnt <= lim, "kept count above slot limit")

endmodule

`default_nettype wire

/* verif/radar_plot_window_gate_tb.sv */
// Testbench for radar_plot_window_gate: window gating, per-frame compaction and slot output.
`timescale 1ns / 1ps

module radar_plot_window_gate_tb;
    import rpwg_pkg::*;

    localparam int MAX_POINTS  = 32;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic              frame_sel;
        logic [RangeW-1:0] range_q;
        logic [AngW-1:0]   elev_q;
        logic [AngW-1:0]   azim_q;
        logic              flag_in;
        logic [PayW-1:0]   payload;
        logic              last_in;
    } detection_t;

    typedef struct packed {
        logic [SlotW-1:0]  slot;
        logic              kept;
        logic [RangeW-1:0] rng;
        logic [AngW-1:0]   elev;
        logic [AngW-1:0]   azim;
        logic [PayW-1:0]   payload;
        logic              last;
    } slot_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cfg_we = 1'b0;
    t_reg_idx            cfg_idx = REG_RANGE_MIN;
    logic [CfgDataW-1:0] i_cfg_data = '0;
    logic                i_frame_sel = 1'b0;
    logic [RangeW-1:0]   i_range_q = '0;
    logic [AngW-1:0]     i_elev_q = '0;
    logic [AngW-1:0]     i_azim_q = '0;
    logic                i_flag_in = 1'b0;
    logic [PayW-1:0]     i_payload = '0;
    logic                i_last_in = 1'b0;
    logic                o_strobe;
    logic [SlotW-1:0]    o_out_slot;
    logic                o_out_valid;
    logic [RangeW-1:0]   o_out_range;
    logic [AngW-1:0]     o_out_elev;
    logic [AngW-1:0]     o_out_azim;
    logic [PayW-1:0]     o_out_payload;
    logic                o_out_last;

    radar_plot_window_gate #(.MAX_POINTS(MAX_POINTS)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_frame_sel   (i_frame_sel),
        .i_range_q     (i_range_q),
        .i_elev_q      (i_elev_q),
        .i_azim_q      (i_azim_q),
        .i_flag_in     (i_flag_in),
        .i_payload     (i_payload),
        .i_last_in     (i_last_in),
        .o_strobe      (o_strobe),
        .o_out_slot    (o_out_slot),
        .o_out_valid   (o_out_valid),
        .o_out_range   (o_out_range),
        .o_out_elev    (o_out_elev),
        .o_out_azim    (o_out_azim),
        .o_out_payload (o_out_payload),
        .o_out_last    (o_out_last)
    );

    // predictor state
    logic [RangeW-1:0]      cfg_range_min, cfg_range_max;
    logic signed [AngW-1:0] cfg_elev_min, cfg_elev_max, cfg_azim_min, cfg_azim_max;
    logic [PcntW-1:0]       cfg_point_count;
    logic [RangeW-1:0]      win_rlo, win_rhi;
    logic signed [AngW-1:0] win_elo, win_ehi, win_alo, win_ahi;
    logic [RangeW-1:0]      kept_range   [2*MAX_POINTS];
    logic [AngW-1:0]        kept_elev    [2*MAX_POINTS];
    logic [AngW-1:0]        kept_azim    [2*MAX_POINTS];
    logic [PayW-1:0]        kept_payload [2*MAX_POINTS];
    int                     prev_kept, cur_kept;

    slot_t pending_slots[$];
    int    mismatch_cnt = 0;
    int    gap_max = 14;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("radar_plot_window_gate regression: fail");
        $finish;
    end

    function automatic int slot_limit();
        return (cfg_point_count > MAX_POINTS) ? MAX_POINTS : int'(cfg_point_count);
    endfunction

    function automatic void update_window();
        win_rlo = cfg_range_min;
        win_rhi = (cfg_range_max > win_rlo) ? cfg_range_max : RangeDefHigh;
        win_elo = (cfg_elev_min >= -ElevLimit && cfg_elev_min < cfg_elev_max) ?
                  cfg_elev_min : ElevDefLow;
        win_ehi = (cfg_elev_max > win_elo && cfg_elev_max <= ElevLimit) ?
                  cfg_elev_max : ElevDefHigh;
        win_alo = (cfg_azim_min >= -AzimLimit && cfg_azim_min < cfg_azim_max) ?
                  cfg_azim_min : AzimDefLow;
        win_ahi = (cfg_azim_max > win_alo && cfg_azim_max <= AzimLimit) ?
                  cfg_azim_max : AzimDefHigh;
    endfunction

    function automatic void reset_model();
        cfg_range_min   = RangeDefLow;
        cfg_range_max   = RangeDefHigh;
        cfg_elev_min    = ElevDefLow;
        cfg_elev_max    = ElevDefHigh;
        cfg_azim_min    = AzimDefLow;
        cfg_azim_max    = AzimDefHigh;
        cfg_point_count = PcntDef;
        prev_kept       = 0;
        cur_kept        = 0;
        update_window();
    endfunction

    function automatic void apply_reg_write(t_reg_idx idx, logic [CfgDataW-1:0] data);
        case (idx)
            REG_RANGE_MIN:   cfg_range_min = data;
            REG_RANGE_MAX:   cfg_range_max = data;
            REG_ELEV_MIN:    cfg_elev_min = data[AngW-1:0];
            REG_ELEV_MAX:    cfg_elev_max = data[AngW-1:0];
            REG_AZIM_MIN:    cfg_azim_min = data[AngW-1:0];
            REG_AZIM_MAX:    cfg_azim_max = data[AngW-1:0];
            REG_POINT_COUNT: cfg_point_count = data[PcntW-1:0];
            default: ;
        endcase
        update_window();
    endfunction

    // gate one accepted detection; on the last item queue the emitted slots
    function automatic void gate_detection(detection_t d);
        int    lim, base, n, idx, k;
        logic  keep;
        slot_t s;
        lim  = slot_limit();
        keep = d.flag_in && d.range_q >= win_rlo && d.range_q <= win_rhi &&
               $signed(d.elev_q) >= win_elo && $signed(d.elev_q) <= win_ehi &&
               $signed(d.azim_q) >= win_alo && $signed(d.azim_q) <= win_ahi;
        if (keep && (d.frame_sel ? cur_kept : prev_kept) < lim) begin
            idx = d.frame_sel ? MAX_POINTS + cur_kept : prev_kept;
            kept_range[idx]   = d.range_q;
            kept_elev[idx]    = d.elev_q;
            kept_azim[idx]    = d.azim_q;
            kept_payload[idx] = d.payload;
            if (d.frame_sel) cur_kept++;
            else prev_kept++;
        end
        if (d.last_in) begin
            base = (cur_kept > 0) ? MAX_POINTS : 0;
            n    = (cur_kept > 0) ? cur_kept : prev_kept;
            for (k = 0; k < lim; k++) begin
                s      = '0;
                s.slot = SlotW'(k);
                s.last = (k + 1 == lim);
                if (k < n) begin
                    s.kept    = 1'b1;
                    s.rng     = kept_range[base+k];
                    s.elev    = kept_elev[base+k];
                    s.azim    = kept_azim[base+k];
                    s.payload = kept_payload[base+k];
                end
                pending_slots.push_back(s);
            end
            prev_kept = 0;
            cur_kept  = 0;
        end
    endfunction

    function automatic void report_mismatch(string what, slot_t want, slot_t got);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("  expected slot %0d valid %0b range %0d elev %0d azim %0d payload %h last %0b",
                     want.slot, want.kept, want.rng, $signed(want.elev), $signed(want.azim),
                     want.payload, want.last);
            $display("  actual   slot %0d valid %0b range %0d elev %0d azim %0d payload %h last %0b",
                     got.slot, got.kept, got.rng, $signed(got.elev), $signed(got.azim),
                     got.payload, got.last);
        end
    endfunction

    always @(posedge i_clk) begin
        slot_t got, want;
        if (i_rst_n) begin
            if (o_strobe) begin
                got = {o_out_slot, o_out_valid, o_out_range, o_out_elev, o_out_azim,
                       o_out_payload, o_out_last};
                if (pending_slots.size() == 0) begin
                    report_mismatch("slot transfer with none expected", '0, got);
                end else begin
                    want = pending_slots.pop_front();
                    if (got !== want) report_mismatch("slot mismatch", want, got);
                end
            end
            if (i_cfg_we) apply_reg_write(cfg_idx, i_cfg_data);
            if (start && !busy)
                gate_detection({i_frame_sel, i_range_q, i_elev_q, i_azim_q, i_flag_in,
                                i_payload, i_last_in});
        end
    end

    task automatic send_detection(detection_t d);
        int gap;
        gap = $urandom_range(0, gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_frame_sel = d.frame_sel;
        i_range_q   = d.range_q;
        i_elev_q    = d.elev_q;
        i_azim_q    = d.azim_q;
        i_flag_in   = d.flag_in;
        i_payload   = d.payload;
        i_last_in   = d.last_in;
        start       = 1'b1;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off until every queued slot has arrived and the block is quiet
    task automatic wait_idle();
        @(negedge i_clk);
        start = 1'b0;
        repeat (2) @(negedge i_clk);
        while (pending_slots.size() != 0 || busy) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CfgDataW-1:0] data);
        @(negedge i_clk);
        cfg_idx    = idx;
        i_cfg_data = data;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    function automatic logic [CfgDataW-1:0] sext_ang(int v);
        logic [AngW-1:0] a;
        a = v[AngW-1:0];
        return {{(CfgDataW-AngW){a[AngW-1]}}, a};
    endfunction

    function automatic int pick_between(int lo, int hi);
        return (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : lo;
    endfunction

    function automatic detection_t det(logic sel, int rng, int elev, int azim,
                                       logic flag, logic last);
        detection_t d;
        d.frame_sel = sel;
        d.range_q   = rng[RangeW-1:0];
        d.elev_q    = elev[AngW-1:0];
        d.azim_q    = azim[AngW-1:0];
        d.flag_in   = flag;
        d.payload   = {$urandom, $urandom};
        d.last_in   = last;
        return d;
    endfunction

    function automatic detection_t random_detection(logic sel, logic last);
        int r, e, a;
        if ($urandom_range(0, 3) != 0) begin
            r = pick_between(int'(win_rlo), int'(win_rhi));
            e = pick_between(int'(win_elo), int'(win_ehi));
            a = pick_between(int'(win_alo), int'(win_ahi));
            return det(sel, r, e, a, 1'b1, last);
        end
        return det(sel, int'($urandom), int'($urandom), int'($urandom),
                   1'($urandom_range(0, 1)), last);
    endfunction

    task automatic test_default_windows();
        detection_t d;
        send_detection(det(1'b0, 1600, -1430, -8577, 1'b1, 1'b0));
        send_detection(det(1'b0, 800000, 8577, 8577, 1'b1, 1'b0));
        send_detection(det(1'b1, 1599, 0, 0, 1'b1, 1'b0));
        send_detection(det(1'b1, 800001, 0, 0, 1'b1, 1'b0));
        d = det(1'b1, 0, -32768, -32768, 1'b1, 1'b0);
        d.payload = '0;
        send_detection(d);
        send_detection(det(1'b1, 1048575, 32767, 32767, 1'b1, 1'b0));
        send_detection(det(1'b1, 5000, -1431, 8578, 1'b1, 1'b0));
        send_detection(det(1'b1, 5000, 8578, -8578, 1'b1, 1'b0));
        send_detection(det(1'b1, 4000, 100, -100, 1'b0, 1'b0));
        d = det(1'b1, 4000, 8577, -8577, 1'b1, 1'b1);
        d.payload = '1;
        send_detection(d);
        wait_idle();
    endtask

    task automatic test_prev_frame_fallback();
        send_detection(det(1'b0, 3000, 10, 20, 1'b1, 1'b0));
        send_detection(det(1'b1, 3000, 10, 20, 1'b0, 1'b0));
        send_detection(det(1'b1, 3000, 10, 20, 1'b0, 1'b1));
        // last item tagged previous frame
        send_detection(det(1'b0, 9000, -5, 5, 1'b1, 1'b1));
        // neither frame keeps anything
        send_detection(det(1'b1, 9000, -5, 5, 1'b0, 1'b1));
        wait_idle();
    endtask

    task automatic test_frame_overflow();
        int k;
        write_reg(REG_POINT_COUNT, 20'd2);
        for (k = 0; k < 3; k++) send_detection(det(1'b0, 2000 + k, k, -k, 1'b1, 1'b0));
        for (k = 0; k < 3; k++) send_detection(det(1'b1, 7000 + k, k, k, 1'b1, k == 2));
        wait_idle();
    endtask

    task automatic test_window_fallback();
        write_reg(REG_RANGE_MIN, 20'd0);
        write_reg(REG_RANGE_MAX, 20'hFFFFF);
        write_reg(REG_ELEV_MIN, sext_ang(-12861));
        write_reg(REG_ELEV_MAX, sext_ang(12861));
        write_reg(REG_AZIM_MIN, sext_ang(-25735));
        write_reg(REG_AZIM_MAX, sext_ang(25735));
        send_detection(det(1'b1, 0, -12861, 25735, 1'b1, 1'b0));
        send_detection(det(1'b1, 1048575, 12861, -25735, 1'b1, 1'b1));
        wait_idle();
        // every bound but the range minimum fails its sanity check
        write_reg(REG_RANGE_MIN, 20'd5000);
        write_reg(REG_RANGE_MAX, 20'd5000);
        write_reg(REG_ELEV_MIN, sext_ang(-12862));
        write_reg(REG_ELEV_MAX, sext_ang(12862));
        write_reg(REG_AZIM_MIN, sext_ang(30000));
        write_reg(REG_AZIM_MAX, sext_ang(-30000));
        send_detection(det(1'b1, 800000, -1430, 8577, 1'b1, 1'b0));
        send_detection(det(1'b1, 5000, 8577, -8577, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_slot_count_limits();
        write_reg(REG_POINT_COUNT, 20'd0);
        send_detection(det(1'b1, 6000, 0, 0, 1'b1, 1'b1));
        wait_idle();
        write_reg(REG_UNUSED, 20'hABCDE);
        write_reg(REG_POINT_COUNT, 20'd127);
        send_detection(det(1'b0, 6000, 0, 0, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic randomize_config();
        int lo, pick;
        pick = $urandom_range(0, 7);
        lo   = (pick == 0) ? 0 : (pick == 1) ? 1048575 : int'($urandom_range(0, 40000));
        write_reg(REG_RANGE_MIN, lo[CfgDataW-1:0]);
        pick = $urandom_range(0, 7);
        write_reg(REG_RANGE_MAX, (pick == 0) ? 20'hFFFFF :
                                 (pick == 1) ? 20'($urandom) :
                                 20'(pick_between(lo + 1, 1048575)));
        if ($urandom_range(0, 3) != 0) begin
            write_reg(REG_ELEV_MIN, sext_ang(-int'($urandom_range(0, 12861))));
            write_reg(REG_ELEV_MAX, sext_ang($urandom_range(1, 12861)));
            write_reg(REG_AZIM_MIN, sext_ang(-int'($urandom_range(0, 25735))));
            write_reg(REG_AZIM_MAX, sext_ang($urandom_range(1, 25735)));
        end else begin
            write_reg(REG_ELEV_MIN, sext_ang($urandom));
            write_reg(REG_ELEV_MAX, sext_ang($urandom));
            write_reg(REG_AZIM_MIN, sext_ang($urandom));
            write_reg(REG_AZIM_MAX, sext_ang($urandom));
        end
        case ($urandom_range(0, 9))
            0:       write_reg(REG_POINT_COUNT, 20'd0);
            1:       write_reg(REG_POINT_COUNT, 20'($urandom_range(33, 127)));
            2:       write_reg(REG_POINT_COUNT, 20'(MAX_POINTS));
            3:       write_reg(REG_POINT_COUNT, 20'd64);
            default: write_reg(REG_POINT_COUNT, 20'($urandom_range(1, 8)));
        endcase
    endtask

    task automatic test_random_traffic();
        int sent, n_prev, n_cur, lim, k;
        sent = 0;
        while (sent < 200) begin
            wait_idle();
            randomize_config();
            gap_max = ($urandom_range(0, 2) == 0) ? 0 : 14;
            lim = slot_limit();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0)
                    send_detection(det(1'($urandom_range(0, 1)), int'($urandom),
                                       int'($urandom), int'($urandom),
                                       1'($urandom_range(0, 1)), 1'b0));
                n_prev = $urandom_range(0, lim + 2);
                n_cur  = $urandom_range(0, lim + 2);
                for (k = 0; k < n_prev; k++) send_detection(random_detection(1'b0, 1'b0));
                for (k = 0; k < n_cur; k++)
                    send_detection(random_detection(1'b1, k == n_cur - 1));
                if (n_cur == 0)
                    send_detection(random_detection(1'($urandom_range(0, 1)), 1'b1));
                sent += n_prev + n_cur + 1;
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_default_windows();
        test_prev_frame_fallback();
        test_frame_overflow();
        test_window_fallback();
        test_slot_count_limits();
        test_random_traffic();
        wait_idle();
        if (mismatch_cnt == 0 && pending_slots.size() == 0) begin
            $display("radar_plot_window_gate regression: pass");
        end else begin
            $display("radar_plot_window_gate regression: fail");
        end
        $finish;
    end

endmodule

/* radar_plot_window_gate.f */
+incdir+hw/rtl
hw/rtl/rpwg_pkg.sv
hw/rtl/radar_plot_window_gate.sv
verif/radar_plot_window_gate_tb.sv
